### rtl/integer_to_roman_symbols_unit_defines.svh
// Assertion macros for the Roman numeral unit.
// Included by the top level; depends on nothing else.
`ifndef INTEGER_TO_ROMAN_SYMBOLS_UNIT_DEFINES_SVH
`define INTEGER_TO_ROMAN_SYMBOLS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define I2R_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define I2R_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/i2r_pkg.sv
// Shared types, constants and the value table of the Roman numeral unit.
// Used by every module of the unit; depends on nothing.
`default_nettype none

package i2r_pkg;

   localparam int unsigned VALUE_WIDTH       = 22;
   localparam int unsigned AMOUNT_WIDTH      = 20;
   localparam int unsigned INDEX_WIDTH       = 5;
   localparam int unsigned LETTER_WIDTH      = 3;
   localparam int unsigned TABLE_LEN         = 25;
   localparam int unsigned OVERLINED_ENTRIES = 12;

   localparam logic [VALUE_WIDTH-1:0] MAX_VALUE = 22'd3999999;

   // letter codes
   localparam logic [LETTER_WIDTH-1:0] LETTER_I = 3'd0;
   localparam logic [LETTER_WIDTH-1:0] LETTER_V = 3'd1;
   localparam logic [LETTER_WIDTH-1:0] LETTER_X = 3'd2;
   localparam logic [LETTER_WIDTH-1:0] LETTER_L = 3'd3;
   localparam logic [LETTER_WIDTH-1:0] LETTER_C = 3'd4;
   localparam logic [LETTER_WIDTH-1:0] LETTER_D = 3'd5;
   localparam logic [LETTER_WIDTH-1:0] LETTER_M = 3'd6;

   // classified item passed from front to back
   typedef struct packed {
      logic                   error;
      logic [VALUE_WIDTH-1:0] value;
   } job_type;

   // one entry of the greedy value table
   typedef struct packed {
      logic [AMOUNT_WIDTH-1:0] amount;
      logic                    pair;
      logic [LETTER_WIDTH-1:0] first;
      logic [LETTER_WIDTH-1:0] second;
   } entry_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SCAN,
      BACK_SECOND
   } back_state_type;

   function automatic entry_type table_entry(input logic [INDEX_WIDTH-1:0] idx);
      entry_type e;
      case (idx)
         5'd0:    e = '{20'd1000000, 1'b0, LETTER_M, LETTER_I};
         5'd1:    e = '{20'd900000,  1'b1, LETTER_C, LETTER_M};
         5'd2:    e = '{20'd500000,  1'b0, LETTER_D, LETTER_I};
         5'd3:    e = '{20'd400000,  1'b1, LETTER_C, LETTER_D};
         5'd4:    e = '{20'd100000,  1'b0, LETTER_C, LETTER_I};
         5'd5:    e = '{20'd90000,   1'b1, LETTER_X, LETTER_C};
         5'd6:    e = '{20'd50000,   1'b0, LETTER_L, LETTER_I};
         5'd7:    e = '{20'd40000,   1'b1, LETTER_X, LETTER_L};
         5'd8:    e = '{20'd10000,   1'b0, LETTER_X, LETTER_I};
         5'd9:    e = '{20'd9000,    1'b1, LETTER_I, LETTER_X};
         5'd10:   e = '{20'd5000,    1'b0, LETTER_V, LETTER_I};
         5'd11:   e = '{20'd4000,    1'b1, LETTER_I, LETTER_V};
         5'd12:   e = '{20'd1000,    1'b0, LETTER_M, LETTER_I};
         5'd13:   e = '{20'd900,     1'b1, LETTER_C, LETTER_M};
         5'd14:   e = '{20'd500,     1'b0, LETTER_D, LETTER_I};
         5'd15:   e = '{20'd400,     1'b1, LETTER_C, LETTER_D};
         5'd16:   e = '{20'd100,     1'b0, LETTER_C, LETTER_I};
         5'd17:   e = '{20'd90,      1'b1, LETTER_X, LETTER_C};
         5'd18:   e = '{20'd50,      1'b0, LETTER_L, LETTER_I};
         5'd19:   e = '{20'd40,      1'b1, LETTER_X, LETTER_L};
         5'd20:   e = '{20'd10,      1'b0, LETTER_X, LETTER_I};
         5'd21:   e = '{20'd9,       1'b1, LETTER_I, LETTER_X};
         5'd22:   e = '{20'd5,       1'b0, LETTER_V, LETTER_I};
         5'd23:   e = '{20'd4,       1'b1, LETTER_I, LETTER_V};
         default: e = '{20'd1,       1'b0, LETTER_I, LETTER_I};
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

### rtl/i2r_front.sv
// Front end: accepts numbers, flags invalid ones and queues them for the back end.
// Depends on i2r_pkg.
`default_nettype none

module i2r_front #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire logic [i2r_pkg::VALUE_WIDTH-1:0]      req_value,
   output logic                                      job_valid,
   output i2r_pkg::job_type                          job,
   input  wire logic                                 job_take
);

   localparam int unsigned PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]   LAST_PTR   = PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(QUEUE_DEPTH);

   i2r_pkg::job_type       queue_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   i2r_pkg::job_type       classified;
   logic                   push_ok;
   logic                   pop_ok;

   // classify: zero or beyond the largest numeral is an error
   always_comb begin
      classified.value = req_value;
      classified.error = (req_value == '0) || (req_value > i2r_pkg::MAX_VALUE);
   end

   assign req_full  = (count_ff == FULL_COUNT);
   assign job_valid = (count_ff != '0);
   assign job       = queue_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = job_take && job_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

`default_nettype wire

### rtl/i2r_back.sv
// Back end: greedy subtraction over the value table, at most one letter per cycle into
// an output register, held while that register is full and not popped. Depends on i2r_pkg.
`default_nettype none

module i2r_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 job_valid,
   input  wire i2r_pkg::job_type                     job,
   output logic                                      job_take,
   output logic                                      back_idle,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output logic [i2r_pkg::LETTER_WIDTH-1:0]          rsp_letter,
   output logic                                      rsp_overline,
   output logic                                      rsp_error,
   output logic                                      rsp_last
);

   i2r_pkg::back_state_type              state_ff, state_in;
   logic [i2r_pkg::VALUE_WIDTH-1:0]      rest_ff, rest_in;
   logic [i2r_pkg::INDEX_WIDTH-1:0]      idx_ff, idx_in;
   logic                                 out_valid_ff, out_valid_in;
   logic [i2r_pkg::LETTER_WIDTH-1:0]     letter_ff, letter_in;
   logic                                 overline_ff, overline_in;
   logic                                 error_ff, error_in;
   logic                                 last_ff, last_in;
   i2r_pkg::entry_type                   entry;
   logic [i2r_pkg::VALUE_WIDTH-1:0]      amount;
   logic [i2r_pkg::VALUE_WIDTH-1:0]      diff;
   logic                                 fits;
   logic                                 over_entry;
   logic                                 out_free;
   logic                                 emit;

   assign entry      = i2r_pkg::table_entry(idx_ff);
   assign amount     = {{(i2r_pkg::VALUE_WIDTH - i2r_pkg::AMOUNT_WIDTH){1'b0}}, entry.amount};
   assign fits       = (rest_ff >= amount);
   assign diff       = rest_ff - amount;
   assign over_entry = (idx_ff < i2r_pkg::INDEX_WIDTH'(i2r_pkg::OVERLINED_ENTRIES));
   assign out_free   = !out_valid_ff || rsp_pop;

   // sequencer: next state and emitted letter
   always_comb begin
      state_in    = state_ff;
      rest_in     = rest_ff;
      idx_in      = idx_ff;
      letter_in   = letter_ff;
      overline_in = overline_ff;
      error_in    = error_ff;
      last_in     = last_ff;
      emit        = 1'b0;
      job_take    = 1'b0;
      case (state_ff)
         i2r_pkg::BACK_IDLE: begin
            if (job_valid && out_free) begin
               job_take = 1'b1;
               if (job.error) begin
                  emit        = 1'b1;
                  letter_in   = i2r_pkg::LETTER_I;
                  overline_in = 1'b0;
                  error_in    = 1'b1;
                  last_in     = 1'b1;
               end else begin
                  rest_in  = job.value;
                  idx_in   = '0;
                  state_in = i2r_pkg::BACK_SCAN;
               end
            end
         end
         i2r_pkg::BACK_SCAN: begin
            if (!fits) begin
               idx_in = idx_ff + 1'b1;
            end else if (out_free) begin
               emit        = 1'b1;
               letter_in   = entry.first;
               overline_in = over_entry;
               error_in    = 1'b0;
               rest_in     = diff;
               if (entry.pair) begin
                  last_in  = 1'b0;
                  state_in = i2r_pkg::BACK_SECOND;
               end else begin
                  last_in = (diff == '0);
                  if (diff == '0) begin
                     state_in = i2r_pkg::BACK_IDLE;
                  end
               end
            end
         end
         i2r_pkg::BACK_SECOND: begin
            // amount was already taken off with the first letter
            if (out_free) begin
               emit        = 1'b1;
               letter_in   = entry.second;
               overline_in = over_entry;
               error_in    = 1'b0;
               last_in     = (rest_ff == '0);
               state_in    = (rest_ff == '0) ? i2r_pkg::BACK_IDLE : i2r_pkg::BACK_SCAN;
            end
         end
         default: begin
            state_in = i2r_pkg::BACK_IDLE;
         end
      endcase
      out_valid_in = emit || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2r_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath and output payload, no reset needed
   always_ff @(posedge clock) begin
      rest_ff     <= rest_in;
      idx_ff      <= idx_in;
      letter_ff   <= letter_in;
      overline_ff <= overline_in;
      error_ff    <= error_in;
      last_ff     <= last_in;
   end

   assign back_idle    = (state_ff == i2r_pkg::BACK_IDLE);
   assign rsp_empty    = !out_valid_ff;
   assign rsp_letter   = letter_ff;
   assign rsp_overline = overline_ff;
   assign rsp_error    = error_ff;
   assign rsp_last     = last_ff;

endmodule

`default_nettype wire

### rtl/integer_to_roman_symbols_unit.sv
// Roman numeral unit (vinculum form), top level. An error result goes straight from the
// queue into the output register when the back end takes it; a valid number is loaded
// into the sequencer, which walks the value table and emits the letters of each entry
// that fits into the output register. The back end takes a new number only when idle,
// while a queue of QUEUE_DEPTH entries (2 by default) runs ahead.
// Reset: synchronous, active high; queue and output register come up empty.
`default_nettype none
`include "integer_to_roman_symbols_unit_defines.svh"

module integer_to_roman_symbols_unit #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire logic [i2r_pkg::VALUE_WIDTH-1:0]      req_value,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output logic [i2r_pkg::LETTER_WIDTH-1:0]          rsp_letter,
   output logic                                      rsp_overline,
   output logic                                      rsp_error,
   output logic                                      rsp_last
);

   logic             job_valid;
   logic             job_take;
   logic             back_idle;
   i2r_pkg::job_type job;

   i2r_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_value (req_value),
      .job_valid (job_valid),
      .job       (job),
      .job_take  (job_take)
   );

   i2r_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job          (job),
      .job_take     (job_take),
      .back_idle    (back_idle),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_letter   (rsp_letter),
      .rsp_overline (rsp_overline),
      .rsp_error    (rsp_error),
      .rsp_last     (rsp_last)
   );

   // an error result stands alone with cleared letter fields
   `I2R_ASSERT_IMPL(a_error_alone, clock, reset, !rsp_empty && rsp_error,
      rsp_last && (rsp_letter == i2r_pkg::LETTER_I) && !rsp_overline)

   // with the sequencer idle, any waiting letter closes its numeral
   `I2R_ASSERT_IMPL(a_idle_last, clock, reset, back_idle && !rsp_empty, rsp_last)

   // a valid number taken by the back end starts the sequencer
   `I2R_ASSERT_NEXT(a_take_idle, clock, reset, job_take && !job.error, !back_idle)

endmodule

`default_nettype wire
